### rtl/sle_pkg.sv
// sle_pkg: shared types, codes and widths for the sequential list engine.
// Used by sle_ctrl, sle_dpath and sequential_list_engine; depends on nothing.
`default_nettype none

package sle_pkg;

   // Default capacity of the element store
   localparam int unsigned CAPACITY_DEF = 32;

   // Fixed field widths
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned POS_W    = 6;
   localparam int unsigned STATUS_W = 2;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Operation codes
   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_DELETE = 2'd1;
   localparam mode_type MODE_READ   = 2'd2;
   localparam mode_type MODE_FIND   = 2'd3;

   // Result status codes
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_BAD_POS  = 2'd1;
   localparam status_type STATUS_FULL     = 2'd2;
   localparam status_type STATUS_NOTFOUND = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;          // latch a new request, clear the result
      logic       rd_en;         // read the element store
      logic       wr_en;         // write the element store
      logic       wr_sel_value;  // write the request value, else the read data
      logic       cap_data;      // take the read data as result data
      logic       find_cmp;      // compare returned element against the value
      logic       ret_first;     // returned element is the first entry
      logic       cap_next;      // take the read data as the successor
      logic       set_status;    // load status_code into the result
      status_type status_code;
      logic       cnt_inc;       // one more element
      logic       cnt_dec;       // one less element
      logic       publish;       // move the result to the output register
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      mode_type mode;       // mode of the held request
      logic     bad_ins;    // position invalid for insert
      logic     bad_acc;    // position invalid for delete or read
      logic     full;       // list at capacity
      logic     empty;      // list holds nothing
      logic     ins_tail;   // insert lands just past the last entry
      logic     match;      // returned element equals the request value
      logic     out_free;   // output register can take a result this cycle
   } dp_sts_type;

endpackage

`default_nettype wire

### rtl/sle_dpath.sv
// sle_dpath: element store, element count, request and result registers.
// Depends on sle_pkg; driven by sle_ctrl through dp_cmd_type commands.
`default_nettype none

module sle_dpath #(
   parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF,
   localparam int unsigned ADDR_W = $clog2(CAPACITY)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sle_pkg::dp_cmd_type                cmd,
   output sle_pkg::dp_sts_type                sts,
   input  logic [ADDR_W-1:0]                  rd_addr,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic [ADDR_W-1:0]                  ret_addr,
   output logic [ADDR_W-1:0]                  pos_index,
   output logic [ADDR_W-1:0]                  last_index,
   input  logic [sle_pkg::MODE_W-1:0]         req_mode,
   input  logic [sle_pkg::POS_W-1:0]          req_position,
   input  logic signed [sle_pkg::DATA_W-1:0]  req_value,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [sle_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [sle_pkg::DATA_W-1:0]  rsp_data,
   output logic [sle_pkg::POS_W-1:0]          rsp_found_position,
   output logic signed [sle_pkg::DATA_W-1:0]  rsp_prior_value,
   output logic                               rsp_prior_valid,
   output logic signed [sle_pkg::DATA_W-1:0]  rsp_next_value,
   output logic                               rsp_next_valid,
   output logic [sle_pkg::POS_W-1:0]          rsp_list_count,
   output logic                               rsp_is_empty
);
   import sle_pkg::*;

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int unsigned FP_W  = ((ADDR_W + 1 > POS_W) ? ADDR_W + 1 : POS_W);
   localparam int unsigned LC_W  = ((CNT_W > POS_W) ? CNT_W : POS_W);

   // Element store and registered read port
   logic signed [DATA_W-1:0] mem [CAPACITY];
   logic signed [DATA_W-1:0] rdata_ff;
   logic signed [DATA_W-1:0] wr_data;

   // Request registers
   mode_type                 mode_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] value_ff;

   // Element count
   logic [CNT_W-1:0] count_ff, count_in;

   // Working result
   status_type               res_status_ff;
   logic signed [DATA_W-1:0] res_data_ff;
   logic [POS_W-1:0]         res_fpos_ff;
   logic signed [DATA_W-1:0] res_prior_ff;
   logic                     res_prior_vld_ff;
   logic signed [DATA_W-1:0] res_next_ff;
   logic                     res_next_vld_ff;
   logic signed [DATA_W-1:0] prev_data_ff;

   // Output register
   logic rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic [POS_W-1:0]         rsp_fpos_ff;
   logic signed [DATA_W-1:0] rsp_prior_ff;
   logic                     rsp_prior_vld_ff;
   logic signed [DATA_W-1:0] rsp_next_ff;
   logic                     rsp_next_vld_ff;
   logic [POS_W-1:0]         rsp_count_ff;
   logic                     rsp_empty_ff;

   // Position checks in a common width
   logic [CMP_W-1:0] pos_w, cnt_w, pos_m1;
   logic [CNT_W-1:0] cnt_m1;
   logic [FP_W-1:0]  fpos_wide;
   logic [LC_W-1:0]  count_wide;

   assign pos_w      = CMP_W'(pos_ff);
   assign cnt_w      = CMP_W'(count_ff);
   assign pos_m1     = pos_w - CMP_W'(1);
   assign cnt_m1     = count_ff - CNT_W'(1);
   assign pos_index  = pos_m1[ADDR_W-1:0];
   assign last_index = cnt_m1[ADDR_W-1:0];
   assign fpos_wide  = FP_W'(ret_addr) + FP_W'(1);
   assign count_wide = LC_W'(count_ff);

   always_comb begin
      sts          = '0;
      sts.mode     = mode_ff;
      sts.bad_ins  = (pos_ff == '0) || (pos_w > cnt_w + CMP_W'(1));
      sts.bad_acc  = (pos_ff == '0) || (pos_w > cnt_w);
      sts.full     = (count_ff == CNT_W'(CAPACITY));
      sts.empty    = (count_ff == '0);
      sts.ins_tail = (pos_w == cnt_w + CMP_W'(1));
      sts.match    = (rdata_ff == value_ff);
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   // Element store: one write and one registered read per cycle
   assign wr_data = cmd.wr_sel_value ? value_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
   end

   // Element count
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Build the result for the request in flight
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_status_ff    <= STATUS_OK;
         res_data_ff      <= '0;
         res_fpos_ff      <= '0;
         res_prior_ff     <= '0;
         res_prior_vld_ff <= 1'b0;
         res_next_ff      <= '0;
         res_next_vld_ff  <= 1'b0;
      end else begin
         if (cmd.set_status) begin
            res_status_ff <= cmd.status_code;
         end
         if (cmd.cap_data) begin
            res_data_ff <= rdata_ff;
         end
         if (cmd.find_cmp && sts.match) begin
            res_fpos_ff <= fpos_wide[POS_W-1:0];
            if (!cmd.ret_first) begin
               res_prior_ff     <= prev_data_ff;
               res_prior_vld_ff <= 1'b1;
            end
         end
         if (cmd.cap_next) begin
            res_next_ff     <= rdata_ff;
            res_next_vld_ff <= 1'b1;
         end
      end
      // Remember the last scanned element as a predecessor candidate
      if (cmd.find_cmp) begin
         prev_data_ff <= rdata_ff;
      end
   end

   // Output register: hold until the response is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff    <= res_status_ff;
         rsp_data_ff      <= res_data_ff;
         rsp_fpos_ff      <= res_fpos_ff;
         rsp_prior_ff     <= res_prior_ff;
         rsp_prior_vld_ff <= res_prior_vld_ff;
         rsp_next_ff      <= res_next_ff;
         rsp_next_vld_ff  <= res_next_vld_ff;
         rsp_count_ff     <= count_wide[POS_W-1:0];
         rsp_empty_ff     <= (count_ff == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_data           = rsp_data_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_prior_value    = rsp_prior_ff;
   assign rsp_prior_valid    = rsp_prior_vld_ff;
   assign rsp_next_value     = rsp_next_ff;
   assign rsp_next_valid     = rsp_next_vld_ff;
   assign rsp_list_count     = rsp_count_ff;
   assign rsp_is_empty       = rsp_empty_ff;

endmodule

`default_nettype wire

### rtl/sle_ctrl.sv
// sle_ctrl: state machine that sequences each request over the element store.
// Depends on sle_pkg; drives sle_dpath through dp_cmd_type commands.
`default_nettype none

module sle_ctrl #(
   parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF,
   localparam int unsigned ADDR_W = $clog2(CAPACITY)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output sle_pkg::dp_cmd_type cmd,
   input  sle_pkg::dp_sts_type sts,
   output logic [ADDR_W-1:0]   rd_addr,
   output logic [ADDR_W-1:0]   wr_addr,
   output logic [ADDR_W-1:0]   ret_addr,
   input  logic [ADDR_W-1:0]   pos_index,
   input  logic [ADDR_W-1:0]   last_index
);
   import sle_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DECODE    = 4'd1;
   localparam logic [3:0] ST_INS_SHIFT = 4'd2;
   localparam logic [3:0] ST_INS_LAST  = 4'd3;
   localparam logic [3:0] ST_INS_PUT   = 4'd4;
   localparam logic [3:0] ST_DEL_SHIFT = 4'd5;
   localparam logic [3:0] ST_DEL_LAST  = 4'd6;
   localparam logic [3:0] ST_RD_WAIT   = 4'd7;
   localparam logic [3:0] ST_FIND_SCAN = 4'd8;
   localparam logic [3:0] ST_FIND_NEXT = 4'd9;
   localparam logic [3:0] ST_FINISH    = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [ADDR_W-1:0] ret_addr_ff;
   logic              rd_pend_ff;
   logic              done_ff, done_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign ret_addr  = ret_addr_ff;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      cursor_in = cursor_ff;
      done_in   = done_ff;
      rd_addr   = cursor_ff;
      wr_addr   = ret_addr_ff;

      unique case (state_ff)
         // Wait for a request
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end

         // Check the position and pick the walk
         ST_DECODE: begin
            done_in = 1'b0;
            unique case (sts.mode)
               MODE_INSERT: begin
                  if (sts.bad_ins) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_BAD_POS;
                     state_in        = ST_FINISH;
                  end else if (sts.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_FULL;
                     state_in        = ST_FINISH;
                  end else if (sts.ins_tail) begin
                     state_in = ST_INS_PUT;
                  end else begin
                     cursor_in = last_index;
                     state_in  = ST_INS_SHIFT;
                  end
               end
               MODE_DELETE: begin
                  if (sts.bad_acc) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_BAD_POS;
                     state_in        = ST_FINISH;
                  end else begin
                     cursor_in = pos_index;
                     state_in  = ST_DEL_SHIFT;
                  end
               end
               MODE_READ: begin
                  if (sts.bad_acc) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_BAD_POS;
                     state_in        = ST_FINISH;
                  end else begin
                     cmd.rd_en = 1'b1;
                     rd_addr   = pos_index;
                     state_in  = ST_RD_WAIT;
                  end
               end
               MODE_FIND: begin
                  if (sts.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_NOTFOUND;
                     state_in        = ST_FINISH;
                  end else begin
                     cursor_in = '0;
                     state_in  = ST_FIND_SCAN;
                  end
               end
               default: state_in = ST_FINISH;
            endcase
         end

         // Move entries up, last first; each write lands in the cycle after its read
         ST_INS_SHIFT: begin
            cmd.rd_en = 1'b1;
            if (rd_pend_ff) begin
               cmd.wr_en = 1'b1;
               wr_addr   = ret_addr_ff + ADDR_W'(1);
            end
            if (cursor_ff == pos_index) begin
               state_in = ST_INS_LAST;
            end else begin
               cursor_in = cursor_ff - ADDR_W'(1);
            end
         end

         // Drain the last moved entry
         ST_INS_LAST: begin
            cmd.wr_en = 1'b1;
            wr_addr   = ret_addr_ff + ADDR_W'(1);
            state_in  = ST_INS_PUT;
         end

         // Drop the new value into the opened slot
         ST_INS_PUT: begin
            cmd.wr_en        = 1'b1;
            cmd.wr_sel_value = 1'b1;
            wr_addr          = pos_index;
            cmd.cnt_inc      = 1'b1;
            state_in         = ST_FINISH;
         end

         // Read from the removed slot upward; first return is the removed value
         ST_DEL_SHIFT: begin
            cmd.rd_en = 1'b1;
            if (rd_pend_ff) begin
               if (ret_addr_ff == pos_index) begin
                  cmd.cap_data = 1'b1;
               end else begin
                  cmd.wr_en = 1'b1;
                  wr_addr   = ret_addr_ff - ADDR_W'(1);
               end
            end
            if (cursor_ff == last_index) begin
               state_in = ST_DEL_LAST;
            end else begin
               cursor_in = cursor_ff + ADDR_W'(1);
            end
         end

         // Drain the last read and shrink the list
         ST_DEL_LAST: begin
            if (ret_addr_ff == pos_index) begin
               cmd.cap_data = 1'b1;
            end else begin
               cmd.wr_en = 1'b1;
               wr_addr   = ret_addr_ff - ADDR_W'(1);
            end
            cmd.cnt_dec = 1'b1;
            state_in    = ST_FINISH;
         end

         // Take the value read at the position
         ST_RD_WAIT: begin
            cmd.cap_data = 1'b1;
            state_in     = ST_FINISH;
         end

         // Stream reads from the head and compare each returned entry
         ST_FIND_SCAN: begin
            if (!done_ff) begin
               cmd.rd_en = 1'b1;
               if (cursor_ff == last_index) begin
                  done_in = 1'b1;
               end else begin
                  cursor_in = cursor_ff + ADDR_W'(1);
               end
            end
            if (rd_pend_ff) begin
               cmd.find_cmp  = 1'b1;
               cmd.ret_first = (ret_addr_ff == '0);
               if (sts.match) begin
                  if (ret_addr_ff == last_index) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_FIND_NEXT;
                  end
               end else if (ret_addr_ff == last_index) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STATUS_NOTFOUND;
                  state_in        = ST_FINISH;
               end
            end
         end

         // The entry after the match was already in flight
         ST_FIND_NEXT: begin
            cmd.cap_next = 1'b1;
            state_in     = ST_FINISH;
         end

         // Hand the result over once the output register is free
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= cmd.rd_en;
         done_ff    <= done_in;
      end
   end

   // Cursor and address of the read now returning
   always_ff @(posedge clock) begin
      cursor_ff   <= cursor_in;
      ret_addr_ff <= rd_addr;
   end

endmodule

`default_nettype wire

### rtl/sequential_list_engine.sv
// Ordered list of signed 32-bit values held in a single element memory of CAPACITY
// entries. One request is in work at a time; the result sits in an output register, so a
// new request is taken while the previous response waits. A request rejected for its
// position or for a full list skips the walk over the memory; insert and delete move every
// entry from the position to the end, read fetches one entry, and find scans from the head
// to the first match. A finished result that finds the previous response still waiting
// holds until that response is taken. The element memory moves or compares one entry per
// cycle through its one read and one write port. The memory needs no clearing after reset.
// Depends on sle_pkg, sle_ctrl and sle_dpath.
`default_nettype none

module sequential_list_engine #(
   parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sle_pkg::MODE_W-1:0]         req_mode,
   input  logic [sle_pkg::POS_W-1:0]          req_position,
   input  logic signed [sle_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sle_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [sle_pkg::DATA_W-1:0]  rsp_data,
   output logic [sle_pkg::POS_W-1:0]          rsp_found_position,
   output logic signed [sle_pkg::DATA_W-1:0]  rsp_prior_value,
   output logic                               rsp_prior_valid,
   output logic signed [sle_pkg::DATA_W-1:0]  rsp_next_value,
   output logic                               rsp_next_valid,
   output logic [sle_pkg::POS_W-1:0]          rsp_list_count,
   output logic                               rsp_is_empty
);
   import sle_pkg::*;

   localparam int unsigned ADDR_W = $clog2(CAPACITY);

   dp_cmd_type        cmd;
   dp_sts_type        sts;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] ret_addr;
   logic [ADDR_W-1:0] pos_index;
   logic [ADDR_W-1:0] last_index;

   sle_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .sts        (sts),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .ret_addr   (ret_addr),
      .pos_index  (pos_index),
      .last_index (last_index)
   );

   sle_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .rd_addr            (rd_addr),
      .wr_addr            (wr_addr),
      .ret_addr           (ret_addr),
      .pos_index          (pos_index),
      .last_index         (last_index),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_data           (rsp_data),
      .rsp_found_position (rsp_found_position),
      .rsp_prior_value    (rsp_prior_value),
      .rsp_prior_valid    (rsp_prior_valid),
      .rsp_next_value     (rsp_next_value),
      .rsp_next_valid     (rsp_next_valid),
      .rsp_list_count     (rsp_list_count),
      .rsp_is_empty       (rsp_is_empty)
   );

   // A taken request keeps the engine busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while engine was still idle next cycle");

   // A result never overwrites one that has not been taken
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> sts.out_free)
      else $error("result published over a pending response");

   // Loading a request never coincides with a store access
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!cmd.rd_en && !cmd.wr_en))
      else $error("store accessed while loading a request");

   // A failed find reports no match fields
   a_notfound_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NOTFOUND)) |->
         ((rsp_found_position == '0) && !rsp_prior_valid && !rsp_next_valid))
      else $error("find miss carries match fields");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// tb_top: self-checking testbench for sequential_list_engine, a bounded ordered list of
// signed words. An in-bench list mirror predicts every response, which is checked in order.
// Depends on sle_pkg and the sequential_list_engine RTL.
`default_nettype none

module tb_top;
   import sle_pkg::*;

   localparam int CAPACITY       = CAPACITY_DEF;
   localparam int IDLE_PCT       = 17;
   localparam int HOLD_CYCLES    = 200;
   localparam int DRAIN_CYCLES   = CAPACITY + 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // One response as the list mirror predicts it
   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] data;
      logic [POS_W-1:0]  found_position;
      logic [DATA_W-1:0] prior_value;
      logic              prior_valid;
      logic [DATA_W-1:0] next_value;
      logic              next_valid;
      logic [POS_W-1:0]  list_count;
      logic              is_empty;
   } list_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   mode_type                 req_mode = MODE_INSERT;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_data;
   logic [POS_W-1:0]         rsp_found_position;
   logic signed [DATA_W-1:0] rsp_prior_value;
   logic                     rsp_prior_valid;
   logic signed [DATA_W-1:0] rsp_next_value;
   logic                     rsp_next_valid;
   logic [POS_W-1:0]         rsp_list_count;
   logic                     rsp_is_empty;

   // List mirror and the responses still owed by the block
   logic [DATA_W-1:0] list_store [0:CAPACITY-1];
   int                list_len = 0;
   list_result_type   pending_results [$];

   int mismatches  = 0;
   int idle_cycles = 0;
   bit tx_quiet    = 1'b0;
   bit rx_quiet    = 1'b0;
   int hold_req    = 0;
   int hold_seen   = 0;
   int hold_left   = 0;

   sequential_list_engine #(.CAPACITY(CAPACITY)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_data           (rsp_data),
      .rsp_found_position (rsp_found_position),
      .rsp_prior_value    (rsp_prior_value),
      .rsp_prior_valid    (rsp_prior_valid),
      .rsp_next_value     (rsp_next_value),
      .rsp_next_valid     (rsp_next_valid),
      .rsp_list_count     (rsp_list_count),
      .rsp_is_empty       (rsp_is_empty)
   );

   always #2 clock = ~clock;

   // Apply one request to the list mirror and return the response it owes
   function automatic list_result_type apply_list_op(mode_type op, logic [POS_W-1:0] p,
                                                     logic [DATA_W-1:0] v);
      list_result_type r;
      int pos;
      int k;
      int hit;
      r = '0;
      pos = p;
      hit = -1;
      case (op)
         MODE_INSERT: begin
            if (pos < 1 || pos > list_len + 1) begin
               r.status = STATUS_BAD_POS;
            end else if (list_len >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               for (k = list_len; k >= pos; k--) list_store[k] = list_store[k-1];
               list_store[pos-1] = v;
               list_len++;
            end
         end
         MODE_DELETE: begin
            if (pos < 1 || pos > list_len) begin
               r.status = STATUS_BAD_POS;
            end else begin
               r.data = list_store[pos-1];
               for (k = pos; k < list_len; k++) list_store[k-1] = list_store[k];
               list_len--;
            end
         end
         MODE_READ: begin
            if (pos < 1 || pos > list_len) r.status = STATUS_BAD_POS;
            else r.data = list_store[pos-1];
         end
         default: begin
            // first match wins; neighbors only where they exist
            for (k = 0; k < list_len; k++) begin
               if (hit < 0 && list_store[k] == v) hit = k;
            end
            if (hit < 0) begin
               r.status = STATUS_NOTFOUND;
            end else begin
               r.found_position = POS_W'(hit + 1);
               if (hit > 0) begin
                  r.prior_value = list_store[hit-1];
                  r.prior_valid = 1'b1;
               end
               if (hit + 1 < list_len) begin
                  r.next_value = list_store[hit+1];
                  r.next_valid = 1'b1;
               end
            end
         end
      endcase
      r.list_count = POS_W'(list_len);
      r.is_empty   = (list_len == 0);
      return r;
   endfunction

   // Offer one request, hold it until taken, then record the response it owes
   task automatic send_request(mode_type op, logic [POS_W-1:0] p, logic [DATA_W-1:0] v);
      while (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= op;
      req_position <= p;
      req_value    <= v;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_list_op(op, p, v));
   endtask

   // Drop valid and wait until every owed response has come back
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Small values (duplicates) in 30 of 100 picks, extremes in 10, the rest full range
   function automatic logic [DATA_W-1:0] random_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) return DATA_W'($urandom_range(7)) - 32'd4;
      if (pick < 40) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // Mostly well-formed requests steered to keep the list length moving, plus noise
   task automatic send_random_op();
      int len;
      int pos;
      int ins_share;
      mode_type op;
      logic [DATA_W-1:0] v;
      len = list_len;
      ins_share = (len < 8) ? 55 : ((len > 30) ? 20 : 35);
      v = random_value();
      if ($urandom_range(99) < 6) begin
         op  = mode_type'($urandom_range(3));
         pos = $urandom_range(63);
      end else begin
         if ($urandom_range(99) < ins_share) begin
            op = MODE_INSERT;
         end else begin
            case ($urandom_range(2))
               0: op = MODE_DELETE;
               1: op = MODE_READ;
               default: op = MODE_FIND;
            endcase
         end
         if ($urandom_range(99) < 8) pos = $urandom_range(63);
         else if (op == MODE_INSERT) pos = $urandom_range(len + 1, 1);
         else pos = (len == 0) ? 1 : $urandom_range(len, 1);
         if (op == MODE_FIND && len > 0 && $urandom_range(99) < 75)
            v = list_store[$urandom_range(len - 1)];
      end
      send_request(op, POS_W'(pos), v);
   endtask

   // Every request against an empty list
   task automatic test_empty_list();
      send_request(MODE_FIND,   6'd0,  32'h0000_0000);
      send_request(MODE_READ,   6'd0,  32'h0000_0000);
      send_request(MODE_DELETE, 6'd1,  32'h0000_0000);
      send_request(MODE_INSERT, 6'd0,  32'h1234_5678);
      send_request(MODE_INSERT, 6'd2,  32'h1234_5678);
      wait_all_results();
   endtask

   // Inserts at head, tail and middle, reads, finds at each end, in the middle and a miss, deletes at each end
   task automatic test_edit_and_find();
      send_request(MODE_INSERT, 6'd1,  32'h7FFF_FFFF);
      send_request(MODE_INSERT, 6'd1,  32'h8000_0000);
      send_request(MODE_INSERT, 6'd3,  32'hFFFF_FFFF);
      send_request(MODE_INSERT, 6'd2,  32'h0000_0000);
      send_request(MODE_READ,   6'd63, 32'hFFFF_FFFF);
      send_request(MODE_READ,   6'd4,  32'h0000_0000);
      send_request(MODE_FIND,   6'd63, 32'h8000_0000);
      send_request(MODE_FIND,   6'd0,  32'hFFFF_FFFF);
      send_request(MODE_FIND,   6'd0,  32'h0000_0000);
      send_request(MODE_FIND,   6'd0,  32'h0000_3039);
      send_request(MODE_INSERT, 6'd2,  32'hFFFF_FFFF);
      send_request(MODE_FIND,   6'd0,  32'hFFFF_FFFF);
      send_request(MODE_DELETE, 6'd1,  32'h0000_0000);
      send_request(MODE_DELETE, 6'd4,  32'h0000_0000);
      send_request(MODE_DELETE, 6'd5,  32'h0000_0000);
      wait_all_results();
   endtask

   // Fill to capacity, then hit the full and range checks at the limit
   task automatic test_full_list();
      while (list_len < CAPACITY)
         send_request(MODE_INSERT, POS_W'($urandom_range(list_len + 1, 1)), $urandom);
      send_request(MODE_INSERT, POS_W'(CAPACITY + 1), $urandom);
      send_request(MODE_INSERT, 6'd1, $urandom);
      send_request(MODE_INSERT, POS_W'(CAPACITY + 2), $urandom);
      send_request(MODE_FIND,   6'd0, list_store[CAPACITY-1]);
      send_request(MODE_READ,   POS_W'(CAPACITY), 32'h0000_0000);
      send_request(MODE_DELETE, POS_W'(CAPACITY), 32'h0000_0000);
      wait_all_results();
   endtask

   // Hold the response side off while requests keep coming, so the block stalls its input
   task automatic test_backpressure();
      tx_quiet = 1'b1;
      hold_req <= hold_req + 1;
      repeat (24) send_random_op();
      tx_quiet = 1'b0;
      wait_all_results();
   endtask

   task automatic test_random_mix(int count, bit calm);
      tx_quiet = calm;
      rx_quiet <= calm;
      repeat (count) send_random_op();
      wait_all_results();
      tx_quiet = 1'b0;
   endtask

   task automatic compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch on rsp_%s: expected %0d (0x%08h), got %0d (0x%08h)",
                     name, $signed(want), want, $signed(got), got);
      end
   endtask

   task automatic check_response();
      list_result_type want;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("response with no request outstanding: status %0d", rsp_status);
         return;
      end
      want = pending_results.pop_front();
      compare_field("status",         want.status,         rsp_status);
      compare_field("data",           want.data,           rsp_data);
      compare_field("found_position", want.found_position, rsp_found_position);
      compare_field("prior_value",    want.prior_value,    rsp_prior_value);
      compare_field("prior_valid",    want.prior_valid,    rsp_prior_valid);
      compare_field("next_value",     want.next_value,     rsp_next_value);
      compare_field("next_valid",     want.next_valid,     rsp_next_valid);
      compare_field("list_count",     want.list_count,     rsp_list_count);
      compare_field("is_empty",       want.is_empty,       rsp_is_empty);
   endtask

   // Response side: check each response, then pick ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_response();
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= rx_quiet || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: end the run if neither side moves a request for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_edit_and_find();
      test_full_list();
      test_backpressure();
      test_random_mix(230, 1'b0);
      test_random_mix(70, 1'b1);
      test_random_mix(40, 1'b0);
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
